### src/mcavg_pkg.sv
package mcavg_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int VREF_W      = 13;
	localparam int GAIN_W      = 16;
	localparam int MV_W        = 16;
	localparam int CH_W        = 3;
	localparam int GAIN_REGS   = 6;
	localparam int SCALE_SHIFT = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_VREF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN5 = 3'd6;

	localparam logic [VREF_W-1:0] VREF_RESET = 13'd3300;

	typedef logic [GAIN_W-1:0] gain_t;
	localparam gain_t GAIN_RESET [GAIN_REGS] = '{
		16'd49152, 16'd19621, 16'd13107, 16'd4096, 16'd4096, 16'd4096
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_DIV,
		ST_VREF,
		ST_GAIN,
		ST_DONE
	} state_t;

	// packed from the top bit down: channel ends up in the lowest bits
	typedef struct packed {
		logic                saturated;
		logic [MV_W-1:0]     voltage_mv;
		logic [SAMPLE_W-1:0] average_raw;
		logic [CH_W-1:0]     channel;
	} result_t;

endpackage

### src/mcavg_ram.sv
module mcavg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/multichannel_adc_average_scaler_unit.sv
// An accepted sample beat passes the READ, ACC, DIV, VREF and GAIN states to DONE, which loads the output register.
// No new sample is taken until the unit is back in IDLE; the shared multiplier makes three passes
// (divide by WINDOW, times vref, times gain) after one sample-store read.
// The output register lets the next sample enter while a result waits.
// Reset: asynchronous, active low; sums, scan position and window slot clear,
// registers take their reset values, and the store reads as zero until first filled.
module multichannel_adc_average_scaler_unit #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mcavg_pkg::IN_TDATA_W-1:0]      s_tdata,  // [11:0] adc_sample
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [2:0] channel, [14:3] average_raw, [30:15] voltage_mv, [31] saturated
	output logic [mcavg_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [mcavg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcavg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_MAX  = WINDOW * ((1 << mcavg_pkg::SAMPLE_W) - 1);
	localparam int SUM_W    = $clog2(SUM_MAX + 1);
	// exact reciprocal: floor(x * DIV_MUL >> DIV_SHIFT) == x / WINDOW for x < 2**SUM_W
	localparam int DIV_SHIFT = SUM_W + SLOT_W;
	localparam int M_W       = SUM_W + 1;
	localparam longint DIV_MUL_L = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [M_W-1:0] DIV_MUL = M_W'(DIV_MUL_L);
	localparam int AV_W = mcavg_pkg::SAMPLE_W + mcavg_pkg::VREF_W;
	localparam int A_W  = (SUM_W > AV_W) ? SUM_W : AV_W;
	localparam int B_W  = (M_W > mcavg_pkg::GAIN_W) ? M_W : mcavg_pkg::GAIN_W;
	localparam int PW   = A_W + B_W;
	localparam int MV_HI = mcavg_pkg::SCALE_SHIFT + mcavg_pkg::MV_W;

	mcavg_pkg::state_t state_q, state_d;

	logic [mcavg_pkg::VREF_W-1:0]   vref_q;
	mcavg_pkg::gain_t               gain_q [mcavg_pkg::GAIN_REGS];
	logic [SUM_W-1:0]               sums_q [CHANNELS];
	logic [mcavg_pkg::CH_W-1:0]     ch_q;
	logic [SLOT_W-1:0]              slot_q;
	logic [ADDR_W-1:0]              base_q;
	logic                           filled_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [mcavg_pkg::SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]               sum_q;
	logic [mcavg_pkg::SAMPLE_W-1:0] avg_q;
	logic [PW-1:0]                  prod_q;
	logic                           out_valid_q;
	mcavg_pkg::result_t             out_q;

	logic                           in_beat;
	logic                           out_load;
	logic                           last_ch;
	logic [mcavg_pkg::SAMPLE_W-1:0] old_rd;
	logic [mcavg_pkg::SAMPLE_W-1:0] old_sample;
	logic [SUM_W:0]                 sum_new;
	logic [A_W-1:0]                 mul_a;
	logic [B_W-1:0]                 mul_b;
	logic [PW-1:0]                  mul_p;
	logic                           sat;
	mcavg_pkg::result_t             res;

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == mcavg_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign last_ch  = (ch_q == mcavg_pkg::CH_W'(CHANNELS - 1));

	mcavg_ram #(
		.WIDTH(mcavg_pkg::SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (state_q == mcavg_pkg::ST_ACC),
		.waddr(addr_q),
		.wdata(sample_q),
		.raddr(addr_q),
		.rdata(old_rd)
	);

	// slots not yet written since reset count as zero
	assign old_sample = filled_q ? old_rd : '0;
	assign sum_new = {1'b0, sums_q[ch_q[CH_IDX_W-1:0]]} - (SUM_W+1)'(old_sample)
		+ (SUM_W+1)'(sample_q);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			mcavg_pkg::ST_DIV: begin
				mul_a = A_W'(sum_q);
				mul_b = B_W'(DIV_MUL);
			end
			mcavg_pkg::ST_VREF: begin
				mul_a = A_W'(prod_q[DIV_SHIFT +: mcavg_pkg::SAMPLE_W]);
				mul_b = B_W'(vref_q);
			end
			mcavg_pkg::ST_GAIN: begin
				mul_a = A_W'(prod_q[AV_W-1:0]);
				mul_b = B_W'(gain_q[ch_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign sat = |prod_q[PW-1:MV_HI];
	assign res.saturated   = sat;
	assign res.voltage_mv  = sat ? '1 : prod_q[mcavg_pkg::SCALE_SHIFT +: mcavg_pkg::MV_W];
	assign res.average_raw = avg_q;
	assign res.channel     = ch_q;

	assign out_load = (state_q == mcavg_pkg::ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcavg_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = mcavg_pkg::ST_READ;
				end
			end
			mcavg_pkg::ST_READ: state_d = mcavg_pkg::ST_ACC;
			mcavg_pkg::ST_ACC:  state_d = mcavg_pkg::ST_DIV;
			mcavg_pkg::ST_DIV:  state_d = mcavg_pkg::ST_VREF;
			mcavg_pkg::ST_VREF: state_d = mcavg_pkg::ST_GAIN;
			mcavg_pkg::ST_GAIN: state_d = mcavg_pkg::ST_DONE;
			mcavg_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = mcavg_pkg::ST_IDLE;
				end
			end
			default: state_d = mcavg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q <= mcavg_pkg::VREF_RESET;
			for (int i = 0; i < mcavg_pkg::GAIN_REGS; i++) begin
				gain_q[i] <= mcavg_pkg::GAIN_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_index == mcavg_pkg::REG_VREF) begin
				vref_q <= cfg_data[mcavg_pkg::VREF_W-1:0];
			end else if (cfg_index inside {[mcavg_pkg::REG_GAIN0:mcavg_pkg::REG_GAIN5]}) begin
				gain_q[cfg_index - mcavg_pkg::REG_GAIN0] <= cfg_data;
			end
		end
	end

	// scan position, window slot and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q     <= '0;
			slot_q   <= '0;
			base_q   <= '0;
			filled_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (state_q == mcavg_pkg::ST_ACC) begin
				sums_q[ch_q[CH_IDX_W-1:0]] <= sum_new[SUM_W-1:0];
			end
			if (out_load) begin
				if (last_ch) begin
					ch_q   <= '0;
					base_q <= '0;
					if (slot_q == SLOT_W'(WINDOW - 1)) begin
						slot_q   <= '0;
						filled_q <= 1'b1;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end else begin
					ch_q   <= ch_q + mcavg_pkg::CH_W'(1);
					base_q <= base_q + ADDR_W'(WINDOW);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= s_tdata[mcavg_pkg::SAMPLE_W-1:0];
			addr_q   <= base_q + ADDR_W'(slot_q);
		end
		if (state_q == mcavg_pkg::ST_ACC) begin
			sum_q <= sum_new[SUM_W-1:0];
		end
		if (state_q == mcavg_pkg::ST_VREF) begin
			avg_q <= prod_q[DIV_SHIFT +: mcavg_pkg::SAMPLE_W];
		end
		if (state_q == mcavg_pkg::ST_DIV || state_q == mcavg_pkg::ST_VREF
			|| state_q == mcavg_pkg::ST_GAIN) begin
			prod_q <= mul_p;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("sample accepted while previous one still in work");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcavg_pkg::ST_DIV) |-> (sum_q <= SUM_W'(SUM_MAX)))
		else $error("running sum beyond window full scale");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q < mcavg_pkg::CH_W'(CHANNELS))
		else $error("scan position beyond last channel");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.saturated) |-> (out_q.voltage_mv == '1))
		else $error("saturated result not clipped to full scale");

endmodule

### bench/mcavg_result_checker.sv
`timescale 1ns / 100ps

module mcavg_result_checker #(
	parameter int CHANNELS = 6,
	parameter int WINDOW   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [mcavg_pkg::IN_TDATA_W-1:0]      s_tdata,  // [11:0] adc_sample
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [2:0] channel, [14:3] average_raw, [30:15] voltage_mv, [31] saturated
	input  logic [mcavg_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [mcavg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcavg_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                    mismatches,
	output int                                    outstanding
);

	localparam int SUM_W   = 16;
	localparam int MV_FULL = 65535;

	logic [mcavg_pkg::SAMPLE_W-1:0] history [CHANNELS][WINDOW];
	logic [SUM_W-1:0]               window_sum [CHANNELS];
	int                             scan_ch;
	int                             slot;
	logic [mcavg_pkg::VREF_W-1:0]   vref;
	mcavg_pkg::gain_t               gain [mcavg_pkg::GAIN_REGS];
	int                             errors;
	mcavg_pkg::result_t             expected_results [$];

	// Replace the oldest sample of the current channel, then scale the new mean.
	function automatic mcavg_pkg::result_t average_and_scale(
		input logic [mcavg_pkg::SAMPLE_W-1:0] sample);
		mcavg_pkg::result_t r;
		logic [SUM_W-1:0]   avg;
		longint unsigned    product;
		window_sum[scan_ch] = window_sum[scan_ch] - SUM_W'(history[scan_ch][slot])
			+ SUM_W'(sample);
		history[scan_ch][slot] = sample;
		avg = window_sum[scan_ch] / WINDOW;
		product = (64'(avg) * 64'(vref) * 64'(gain[scan_ch])) >> mcavg_pkg::SCALE_SHIFT;
		r.channel     = mcavg_pkg::CH_W'(scan_ch);
		r.average_raw = mcavg_pkg::SAMPLE_W'(avg);
		r.saturated   = product > MV_FULL;
		r.voltage_mv  = r.saturated ? '1 : mcavg_pkg::MV_W'(product);
		// advance the window slot once per full scan
		if (scan_ch == CHANNELS - 1) begin
			scan_ch = 0;
			slot = (slot + 1) % WINDOW;
		end else begin
			scan_ch++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mcavg_pkg::result_t got;
		mcavg_pkg::result_t want;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				window_sum[c] = '0;
				for (int w = 0; w < WINDOW; w++)
					history[c][w] = '0;
			end
			for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
				gain[g] = mcavg_pkg::GAIN_RESET[g];
			vref = mcavg_pkg::VREF_RESET;
			scan_ch = 0;
			slot = 0;
			errors = 0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = mcavg_pkg::result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("result beat with nothing expected: tdata=%h", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.channel !== want.channel || got.average_raw !== want.average_raw ||
						got.voltage_mv !== want.voltage_mv || got.saturated !== want.saturated) begin
						if (errors < 10)
							$display({"result mismatch: expected ch=%0d avg=%0d mv=%0d sat=%0b,",
								" got ch=%0d avg=%0d mv=%0d sat=%0b"},
								want.channel, want.average_raw, want.voltage_mv, want.saturated,
								got.channel, got.average_raw, got.voltage_mv, got.saturated);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(
					average_and_scale(s_tdata[mcavg_pkg::SAMPLE_W-1:0]));
			// index beyond the last gain register is dropped
			if (cfg_we) begin
				if (cfg_index == mcavg_pkg::REG_VREF)
					vref = cfg_data[mcavg_pkg::VREF_W-1:0];
				else if (cfg_index >= mcavg_pkg::REG_GAIN0 && cfg_index <= mcavg_pkg::REG_GAIN5)
					gain[cfg_index - mcavg_pkg::REG_GAIN0] = cfg_data[mcavg_pkg::GAIN_W-1:0];
			end
		end
		mismatches <= errors;
		outstanding <= expected_results.size();
	end

endmodule

### bench/tb_multichannel_adc_average_scaler_unit.sv
`timescale 1ns / 100ps

module tb_multichannel_adc_average_scaler_unit;

	localparam int CHANNELS     = 6;
	localparam int WINDOW       = 16;
	localparam int PHASE_ITEMS  = 171;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [mcavg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_LONG
	} rx_mode_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [mcavg_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [mcavg_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                              cfg_we;
	logic [mcavg_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [mcavg_pkg::CFG_DATA_W-1:0]  cfg_data;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int burst_left;
	int samples_sent;

	rx_mode_t rx_mode;
	int       rx_mode_left;
	int       rx_hold;

	logic [mcavg_pkg::SAMPLE_W-1:0]   level [CHANNELS];
	logic [mcavg_pkg::CFG_DATA_W-1:0] next_vref;
	logic [mcavg_pkg::CFG_DATA_W-1:0] next_gain [mcavg_pkg::GAIN_REGS];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	multichannel_adc_average_scaler_unit #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mcavg_result_checker #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL multichannel_adc_average_scaler_unit");
			$finish;
		end
	end

	// Receiver: free-running, coin-toss and long-stall stretches, each picked at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_mode_left <= $urandom_range(50, 300);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_FREE: begin
					m_tready <= 1'b1;
				end
				RX_RANDOM: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				default: begin
					if (rx_hold != 0) begin
						rx_hold <= rx_hold - 1;
					end else begin
						m_tready <= ~m_tready;
						rx_hold <= m_tready ? $urandom_range(1, 20) : $urandom_range(0, 3);
					end
				end
			endcase
		end
	end

	// Hold the beat until taken; close a burst with a random idle gap with valid low.
	task automatic send_word(input logic [mcavg_pkg::IN_TDATA_W-1:0] word);
		s_tdata <= word;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			burst_left = $urandom_range(1, 40);
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic send_sample(input logic [mcavg_pkg::SAMPLE_W-1:0] sample);
		send_word({4'($urandom), sample});
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mcavg_pkg::CFG_IDX_W-1:0] idx,
		input logic [mcavg_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_settings();
		write_reg(mcavg_pkg::REG_VREF, next_vref);
		for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
			write_reg(mcavg_pkg::REG_GAIN0 + mcavg_pkg::CFG_IDX_W'(g), next_gain[g]);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [mcavg_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 16'd4096;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [mcavg_pkg::SAMPLE_W-1:0] pick_level();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// Mostly steady per-channel levels with noise, so the window means settle.
	task automatic run_scans(input int count);
		int ch;
		int pick;
		int v;
		for (int n = 0; n < count; n++) begin
			ch = samples_sent % CHANNELS;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				v = int'(level[ch]) + $urandom_range(0, 16) - 8;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end else if (pick < 75) begin
				v = $urandom_range(0, 4095);
			end else if (pick < 85) begin
				v = 0;
			end else if (pick < 95) begin
				v = 4095;
			end else begin
				level[ch] = pick_level();
				v = level[ch];
			end
			send_sample(mcavg_pkg::SAMPLE_W'(v));
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mcavg_pkg::REG_VREF;
		cfg_data <= '0;
		arst_n <= 1'b0;
		rx_mode = RX_FREE;
		rx_mode_left = 0;
		rx_hold = 0;
		burst_left = $urandom_range(1, 40);
		samples_sent = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start-up scans with reset settings: full scale, alternating bit patterns, then zeros
		for (int c = 0; c < CHANNELS; c++)
			send_sample(12'hFFF);
		for (int c = 0; c < CHANNELS; c++)
			send_sample(12'h555);
		for (int c = 0; c < CHANNELS; c++)
			send_sample(12'hAAA);
		for (int c = 0; c < CHANNELS; c++)
			send_sample(12'h000);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					// raw reference beyond range and full gain: drive into saturation
					next_vref = '1;
					for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
						next_gain[g] = '1;
				end
				1: begin
					next_vref = 16'd1000;
					for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
						next_gain[g] = (g % 2 == 0) ? '0 : '1;
				end
				2: begin
					next_vref = 16'd5000;
					for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
						next_gain[g] = pick_gain();
				end
				default: begin
					next_vref = ($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(1000, 5000));
					for (int g = 0; g < mcavg_pkg::GAIN_REGS; g++)
						next_gain[g] = pick_gain();
				end
			endcase
			for (int c = 0; c < CHANNELS; c++)
				level[c] = (phase == 0) ? 12'hFFF : pick_level();
			load_settings();
			run_scans(PHASE_ITEMS);
			wait_drained();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("PASS multichannel_adc_average_scaler_unit");
		else
			$display("FAIL multichannel_adc_average_scaler_unit");
		$finish;
	end

endmodule

### files.f
src/mcavg_pkg.sv
src/mcavg_ram.sv
src/multichannel_adc_average_scaler_unit.sv
bench/mcavg_result_checker.sv
bench/tb_multichannel_adc_average_scaler_unit.sv
